FILE: hw/rtl/gdr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the grid dda column raycaster
// no dependencies
package gdr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;

	// shared divider operand widths
	localparam int DIV_NW = 33;
	localparam int DIV_DW = 42;

	localparam logic [32:0] DELTA_MAX = 33'h0_7FFF_FFFF;
	localparam logic [32:0] LINE_MAX  = 33'h0_0010_0000;
	localparam logic [23:0] COL_X     = 24'hFF0000;
	localparam logic [23:0] COL_Y     = 24'hFFFFFF;

	// register indexes on the configuration port
	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_DIR_X   = 3'd2;
	localparam logic [2:0] REG_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;
	localparam logic [2:0] REG_SCR_W   = 3'd6;
	localparam logic [2:0] REG_SCR_H   = 3'd7;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_IDLE,
		OP_DIV_CAM,
		OP_CAM,
		OP_MUL_RX,
		OP_RX,
		OP_MUL_RY,
		OP_RY,
		OP_DIV_DX,
		OP_DX,
		OP_DIV_DY,
		OP_DY,
		OP_MUL_SX,
		OP_SX,
		OP_MUL_SY,
		OP_SY,
		OP_STEP,
		OP_DIV_LINE,
		OP_HIT,
		OP_MISS
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic oob;
		logic hit;
		logic steps_done;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic        [21:0] pos_x;
		logic        [21:0] pos_y;
		logic signed [18:0] dir_x;
		logic signed [18:0] dir_y;
		logic signed [18:0] plane_x;
		logic signed [18:0] plane_y;
		logic        [12:0] screen_width;
		logic        [12:0] screen_height;
	} cfg_t;

endpackage

FILE: hw/rtl/gdr_div.sv
`timescale 1ns / 1ps
// restoring unsigned divider, one quotient bit per cycle
// no package dependencies
module gdr_div #(
	parameter int NW = 33,
	parameter int DW = 42
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   shifted;
	logic [DW+1:0] diff;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

FILE: hw/rtl/gdr_dp.sv
`timescale 1ns / 1ps
// raycaster datapath: wall map, ray setup, dda walk, span and output register
// depends on gdr_pkg and gdr_div
module gdr_dp #(
	parameter int MAP_W     = 64,
	parameter int MAP_H     = 64,
	parameter int MAX_STEPS = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gdr_pkg::cmd_t cmd,
	output gdr_pkg::sts_t sts,
	input  gdr_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          kind,
	input  logic [5:0]    cell_x,
	input  logic [5:0]    cell_y,
	input  logic          wall,
	input  logic [11:0]   column,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [11:0]   column_out,
	output logic [11:0]   top_row,
	output logic [11:0]   bottom_row,
	output logic          side,
	output logic [23:0]   colour,
	output logic          wall_found
);
	import gdr_pkg::*;

	localparam int DEPTH   = MAP_W * MAP_H;
	localparam int AW      = $clog2(DEPTH);
	localparam int MAP_MAX = (MAP_W > MAP_H) ? MAP_W : MAP_H;
	localparam int MC_W    = (($clog2(MAP_MAX + 1) > 6) ? $clog2(MAP_MAX + 1) : 6) + 2;
	localparam int SW      = $clog2(MAX_STEPS + 1);

	logic mem [DEPTH];
	logic          rd_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          we;
	logic          accept;

	logic        [11:0]   col_q;
	logic signed [30:0]   cam_q;
	logic signed [32:0]   rx_q, ry_q;
	logic        [30:0]   dx_q, dy_q;
	logic        [41:0]   sx_q, sy_q;
	logic signed [MC_W-1:0] mx_q, my_q;
	logic                 side_q;
	logic        [SW-1:0] steps_q;
	logic signed [50:0]   prod_q;

	logic        out_valid_q;
	logic [11:0] col_out_q, top_q, bot_q;
	logic        side_out_q, found_q;
	logic [23:0] colour_q;

	logic [12:0] w_c, h_c;
	logic [16:0] frac_x, frac_y;
	logic signed [18:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [50:0] prod_d;
	logic signed [50:0] prod_sh;
	logic [32:0] abs_rx, abs_ry;

	logic        div_start, div_done;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den;

	logic go_x;
	logic signed [MC_W-1:0] nmx, nmy;
	logic oob;
	logic [41:0] perp_dist;
	logic [20:0] line;
	logic [11:0] half_h;
	logic [19:0] half_l;
	logic [20:0] bot_sum;
	logic out_free;

	// screen size saturated into 1..4096
	assign w_c = (cfg.screen_width == '0) ? 13'd1 :
		((cfg.screen_width > 13'd4096) ? 13'd4096 : cfg.screen_width);
	assign h_c = (cfg.screen_height == '0) ? 13'd1 :
		((cfg.screen_height > 13'd4096) ? 13'd4096 : cfg.screen_height);

	assign accept   = in_valid && (cmd.op == OP_IDLE);
	assign in_stall = (cmd.op != OP_IDLE);

	// wall map: clearing sweep after reset, cell writes on accept
	assign we = (cmd.op == OP_CLEAR) ||
		(accept && !kind && (int'(cell_x) < MAP_W) && (int'(cell_y) < MAP_H));
	assign wr_addr = (cmd.op == OP_CLEAR) ? clr_q :
		AW'(int'(cell_y) * MAP_W + int'(cell_x));

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= (cmd.op == OP_CLEAR) ? 1'b0 : wall;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.op == OP_CLEAR)
			clr_q <= clr_q + 1'b1;
	end

	// distance to the next grid line, per axis
	assign frac_x = rx_q[32] ? {1'b0, cfg.pos_x[FRAC_BITS-1:0]} :
		17'(ONE) - {1'b0, cfg.pos_x[FRAC_BITS-1:0]};
	assign frac_y = ry_q[32] ? {1'b0, cfg.pos_y[FRAC_BITS-1:0]} :
		17'(ONE) - {1'b0, cfg.pos_y[FRAC_BITS-1:0]};

	assign abs_rx = rx_q[32] ? 33'(-rx_q) : 33'(rx_q);
	assign abs_ry = ry_q[32] ? 33'(-ry_q) : 33'(ry_q);

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_RX: begin
				mul_a = cfg.plane_x;
				mul_b = {cam_q[30], cam_q};
			end
			OP_MUL_RY: begin
				mul_a = cfg.plane_y;
				mul_b = {cam_q[30], cam_q};
			end
			OP_MUL_SX: begin
				mul_a = $signed({2'b00, frac_x});
				mul_b = $signed({1'b0, dx_q});
			end
			OP_MUL_SY: begin
				mul_a = $signed({2'b00, frac_y});
				mul_b = $signed({1'b0, dy_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d  = mul_a * mul_b;
	assign prod_sh = prod_q >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	// shared divider operands
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			OP_DIV_CAM: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(col_q) << (FRAC_BITS + 1);
				div_den   = DIV_DW'(w_c);
			end
			OP_DIV_DX: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(1) << (2 * FRAC_BITS);
				div_den   = DIV_DW'(abs_rx);
			end
			OP_DIV_DY: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(1) << (2 * FRAC_BITS);
				div_den   = DIV_DW'(abs_ry);
			end
			OP_DIV_LINE: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(h_c) << FRAC_BITS;
				div_den   = perp_dist;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	gdr_div #(
		.NW(DIV_NW),
		.DW(DIV_DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// dda step: advance along the axis with the nearer grid line
	assign go_x = sx_q < sy_q;
	assign nmx  = go_x ? (rx_q[32] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
	assign nmy  = go_x ? my_q : (ry_q[32] ? my_q - 1'b1 : my_q + 1'b1);
	assign oob  = nmx[MC_W-1] || nmy[MC_W-1] ||
		(nmx >= MC_W'(MAP_W)) || (nmy >= MC_W'(MAP_H));
	assign rd_addr = AW'(int'(nmy) * MAP_W + int'(nmx));

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_IDLE: begin
				if (accept)
					col_q <= column;
			end
			OP_CAM: begin
				cam_q   <= $signed({1'b0, div_quo[29:0]}) - 31'(ONE);
				mx_q    <= MC_W'(cfg.pos_x[21:FRAC_BITS]);
				my_q    <= MC_W'(cfg.pos_y[21:FRAC_BITS]);
				side_q  <= 1'b0;
				steps_q <= '0;
			end
			OP_RX: rx_q <= 33'(cfg.dir_x) + prod_sh[32:0];
			OP_RY: ry_q <= 33'(cfg.dir_y) + prod_sh[32:0];
			OP_DX: dx_q <= (rx_q == '0 || div_quo > DELTA_MAX) ? DELTA_MAX[30:0] : div_quo[30:0];
			OP_DY: dy_q <= (ry_q == '0 || div_quo > DELTA_MAX) ? DELTA_MAX[30:0] : div_quo[30:0];
			OP_SX: sx_q <= {9'b0, prod_q[48:16]};
			OP_SY: sy_q <= {9'b0, prod_q[48:16]};
			OP_STEP: begin
				if (go_x) begin
					sx_q <= sx_q + 42'(dx_q);
					side_q <= 1'b0;
				end else begin
					sy_q <= sy_q + 42'(dy_q);
					side_q <= 1'b1;
				end
				mx_q    <= nmx;
				my_q    <= nmy;
				steps_q <= steps_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// span from the perpendicular distance
	assign perp_dist = side_q ? (sy_q - 42'(dy_q)) : (sx_q - 42'(dx_q));
	assign line      = (div_quo > LINE_MAX) ? LINE_MAX[20:0] : div_quo[20:0];
	assign half_h    = h_c[12:1];
	assign half_l    = line[20:1];
	assign bot_sum   = 21'(half_l) + 21'(half_h);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((cmd.op == OP_HIT || cmd.op == OP_MISS) && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_HIT && out_free) begin
			col_out_q  <= col_q;
			top_q      <= (20'(half_h) > half_l) ? 12'(20'(half_h) - half_l) : 12'd0;
			bot_q      <= (bot_sum >= 21'(h_c)) ? 12'(h_c - 13'd1) : bot_sum[11:0];
			side_out_q <= side_q;
			colour_q   <= side_q ? COL_Y : COL_X;
			found_q    <= 1'b1;
		end else if (cmd.op == OP_MISS && out_free) begin
			col_out_q  <= col_q;
			top_q      <= '0;
			bot_q      <= '0;
			side_out_q <= 1'b0;
			colour_q   <= '0;
			found_q    <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign column_out = col_out_q;
	assign top_row    = top_q;
	assign bottom_row = bot_q;
	assign side       = side_out_q;
	assign colour     = colour_q;
	assign wall_found = found_q;

	assign sts.clr_done   = (clr_q == AW'(DEPTH - 1));
	assign sts.div_done   = div_done;
	assign sts.oob        = oob;
	assign sts.hit        = rd_q;
	assign sts.steps_done = (steps_q == SW'(MAX_STEPS));
	assign sts.out_free   = out_free;
endmodule

FILE: hw/rtl/gdr_ctrl.sv
`timescale 1ns / 1ps
// raycaster sequencer: map clear, ray setup, walk and span phases
// depends on gdr_pkg
module gdr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          kind,
	input  gdr_pkg::sts_t sts,
	output gdr_pkg::cmd_t cmd
);
	import gdr_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_DCAM, S_WCAM, S_CAM,
		S_MRX, S_RX, S_MRY, S_RY,
		S_DDX, S_WDX, S_LDX, S_DDY, S_WDY, S_LDY,
		S_MSX, S_SX, S_MSY, S_SY,
		S_STEP, S_CHECK,
		S_DLINE, S_WLINE, S_HIT, S_MISS
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE:  if (in_valid && kind) state_q <= S_DCAM;
				S_DCAM:  state_q <= S_WCAM;
				S_WCAM:  if (sts.div_done) state_q <= S_CAM;
				S_CAM:   state_q <= S_MRX;
				S_MRX:   state_q <= S_RX;
				S_RX:    state_q <= S_MRY;
				S_MRY:   state_q <= S_RY;
				S_RY:    state_q <= S_DDX;
				S_DDX:   state_q <= S_WDX;
				S_WDX:   if (sts.div_done) state_q <= S_LDX;
				S_LDX:   state_q <= S_DDY;
				S_DDY:   state_q <= S_WDY;
				S_WDY:   if (sts.div_done) state_q <= S_LDY;
				S_LDY:   state_q <= S_MSX;
				S_MSX:   state_q <= S_SX;
				S_SX:    state_q <= S_MSY;
				S_MSY:   state_q <= S_SY;
				S_SY:    state_q <= S_STEP;
				S_STEP:  state_q <= sts.oob ? S_MISS : S_CHECK;
				S_CHECK: begin
					if (sts.hit)
						state_q <= S_DLINE;
					else if (sts.steps_done)
						state_q <= S_MISS;
					else
						state_q <= S_STEP;
				end
				S_DLINE: state_q <= S_WLINE;
				S_WLINE: if (sts.div_done) state_q <= S_HIT;
				S_HIT:   if (sts.out_free) state_q <= S_IDLE;
				S_MISS:  if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		case (state_q)
			S_CLEAR: cmd.op = OP_CLEAR;
			S_IDLE:  cmd.op = OP_IDLE;
			S_DCAM:  cmd.op = OP_DIV_CAM;
			S_CAM:   cmd.op = OP_CAM;
			S_MRX:   cmd.op = OP_MUL_RX;
			S_RX:    cmd.op = OP_RX;
			S_MRY:   cmd.op = OP_MUL_RY;
			S_RY:    cmd.op = OP_RY;
			S_DDX:   cmd.op = OP_DIV_DX;
			S_LDX:   cmd.op = OP_DX;
			S_DDY:   cmd.op = OP_DIV_DY;
			S_LDY:   cmd.op = OP_DY;
			S_MSX:   cmd.op = OP_MUL_SX;
			S_SX:    cmd.op = OP_SX;
			S_MSY:   cmd.op = OP_MUL_SY;
			S_SY:    cmd.op = OP_SY;
			S_STEP:  cmd.op = OP_STEP;
			S_DLINE: cmd.op = OP_DIV_LINE;
			S_HIT:   cmd.op = OP_HIT;
			S_MISS:  cmd.op = OP_MISS;
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule

FILE: hw/rtl/grid_dda_column_raycaster.sv
`timescale 1ns / 1ps
// Grid DDA column raycaster, top level.
// Input channel (in_valid/in_stall): kind 0 writes one wall map cell, kind 1
// casts one screen column. A write beat gives no result; a cast beat gives
// exactly one result beat on the output channel (out_valid/out_stall) with
// the clamped vertical span, side, colour and a wall_found flag.
// Camera and screen settings sit in APB registers; the user is to write them
// between casts, and the block itself does not enforce this. A cast that hits
// a wall runs four passes of the bit-serial divider and walks at most MAX_STEPS
// cells, each with a step state and a check state for the map read. A miss
// skips the span division; when the walk leaves the map, the miss follows the
// step with no check. in_stall drops in the same cycle the result is loaded.
// After reset the map is cleared one cell a cycle, all MAP_W*MAP_H cells
// (4096 by default), with in_stall high; register writes work meanwhile.
// A finished span waits in the output register while out_stall is high; the
// next input beat is still taken, but a second span holds the sequencer until
// the first has left.
// depends on gdr_pkg, gdr_ctrl, gdr_dp
module grid_dda_column_raycaster #(
	parameter int MAP_W     = 64,
	parameter int MAP_H     = 64,
	parameter int MAX_STEPS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [5:0]  cell_x,
	input  logic [5:0]  cell_y,
	input  logic        wall,
	input  logic [11:0] column,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] column_out,
	output logic [11:0] top_row,
	output logic [11:0] bottom_row,
	output logic        side,
	output logic [23:0] colour,
	output logic        wall_found
);
	import gdr_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x         <= 22'd131072;
			cfg_q.pos_y         <= 22'd131072;
			cfg_q.dir_x         <= 19'sd65536;
			cfg_q.dir_y         <= 19'sd0;
			cfg_q.plane_x       <= 19'sd0;
			cfg_q.plane_y       <= 19'sd43254;
			cfg_q.screen_width  <= 13'd640;
			cfg_q.screen_height <= 13'd480;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_POS_X:   cfg_q.pos_x         <= pwdata[21:0];
				REG_POS_Y:   cfg_q.pos_y         <= pwdata[21:0];
				REG_DIR_X:   cfg_q.dir_x         <= pwdata[18:0];
				REG_DIR_Y:   cfg_q.dir_y         <= pwdata[18:0];
				REG_PLANE_X: cfg_q.plane_x       <= pwdata[18:0];
				REG_PLANE_Y: cfg_q.plane_y       <= pwdata[18:0];
				REG_SCR_W:   cfg_q.screen_width  <= pwdata[12:0];
				REG_SCR_H:   cfg_q.screen_height <= pwdata[12:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_POS_X:   prdata = 32'(cfg_q.pos_x);
			REG_POS_Y:   prdata = 32'(cfg_q.pos_y);
			REG_DIR_X:   prdata = 32'(cfg_q.dir_x);
			REG_DIR_Y:   prdata = 32'(cfg_q.dir_y);
			REG_PLANE_X: prdata = 32'(cfg_q.plane_x);
			REG_PLANE_Y: prdata = 32'(cfg_q.plane_y);
			REG_SCR_W:   prdata = 32'(cfg_q.screen_width);
			REG_SCR_H:   prdata = 32'(cfg_q.screen_height);
			default:     prdata = '0;
		endcase
	end

	gdr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.kind    (kind),
		.sts     (sts),
		.cmd     (cmd)
	);

	gdr_dp #(
		.MAP_W    (MAP_W),
		.MAP_H    (MAP_H),
		.MAX_STEPS(MAX_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.wall      (wall),
		.column    (column),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.column_out(column_out),
		.top_row   (top_row),
		.bottom_row(bottom_row),
		.side      (side),
		.colour    (colour),
		.wall_found(wall_found)
	);
endmodule

FILE: tb/grid_dda_column_raycaster_test.sv
`timescale 1ns / 1ps
// self-checking bench for grid_dda_column_raycaster: map writes and column casts
// against an in-bench span predictor, with random sender gaps and receiver stalls
// depends on gdr_pkg and the grid_dda_column_raycaster rtl
module grid_dda_column_raycaster_test;
	import gdr_pkg::*;

	localparam int WATCHDOG = 200000;
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CAST  = 1'b1;
	localparam int   N_REGS     = 8;

	typedef struct packed {
		logic        kind;
		logic [5:0]  cx;
		logic [5:0]  cy;
		logic        wall;
		logic [11:0] col;
	} beat_t;

	typedef struct packed {
		logic [11:0] col;
		logic [11:0] top;
		logic [11:0] bot;
		logic        side;
		logic [23:0] colour;
		logic        found;
	} span_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic in_valid = 0, in_stall, kind = 0, wall = 0;
	logic [5:0] cell_x = 0, cell_y = 0;
	logic [11:0] column = 0;
	logic out_valid, out_stall = 0, side, wall_found;
	logic [11:0] column_out, top_row, bottom_row;
	logic [23:0] colour;

	grid_dda_column_raycaster DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// predictor state
	logic map_bits [0:4095];
	logic [31:0] cam_regs [N_REGS];
	beat_t pending_beats[$];
	span_t expected_spans[$];
	int errors = 0, casts = 0, hits = 0, writes = 0, idle_cycles = 0;
	bit timed_out = 0;

	function automatic longint sx19(logic [31:0] v);
		return longint'($signed(v[18:0]));
	endfunction

	function automatic longint floor16(longint v);
		return v >>> 16;
	endfunction

	function automatic longint clampd(logic [31:0] v);
		longint x;
		x = v[12:0];
		if (x < 1) return 1;
		if (x > 4096) return 4096;
		return x;
	endfunction

	function automatic longint step_len(longint r);
		longint a, d;
		a = r < 0 ? -r : r;
		if (a == 0) return longint'(DELTA_MAX);
		d = (longint'(1) << 32) / a;
		return d > longint'(DELTA_MAX) ? longint'(DELTA_MAX) : d;
	endfunction

	function automatic span_t cast_span(logic [11:0] c);
		longint one, w, h, cam, rx, ry, dx, dy, sxd, syd, px, py, mx, my, stx, sty;
		longint perp, line, top, bot;
		int sd, fnd;
		span_t s;
		one = ONE; sd = 0; fnd = 0;
		w = clampd(cam_regs[REG_SCR_W]);
		h = clampd(cam_regs[REG_SCR_H]);
		px = cam_regs[REG_POS_X][21:0];
		py = cam_regs[REG_POS_Y][21:0];
		cam = (2 * longint'(c) * one) / w - one;
		rx = sx19(cam_regs[REG_DIR_X]) + floor16(sx19(cam_regs[REG_PLANE_X]) * cam);
		ry = sx19(cam_regs[REG_DIR_Y]) + floor16(sx19(cam_regs[REG_PLANE_Y]) * cam);
		dx = step_len(rx);
		dy = step_len(ry);
		mx = px >> 16;
		my = py >> 16;
		if (rx < 0) begin stx = -1; sxd = ((px - mx * one) * dx) >> 16; end
		else begin stx = 1; sxd = (((mx + 1) * one - px) * dx) >> 16; end
		if (ry < 0) begin sty = -1; syd = ((py - my * one) * dy) >> 16; end
		else begin sty = 1; syd = (((my + 1) * one - py) * dy) >> 16; end
		for (int i = 0; i < 128; i++) begin
			if (sxd < syd) begin sxd += dx; mx += stx; sd = 0; end
			else begin syd += dy; my += sty; sd = 1; end
			if (mx < 0 || mx >= 64 || my < 0 || my >= 64) break;
			if (map_bits[my * 64 + mx]) begin fnd = 1; break; end
		end
		s = '0;
		s.col = c;
		if (!fnd) return s;
		perp = sd == 0 ? sxd - dx : syd - dy;
		if (perp <= 0) line = longint'(LINE_MAX);
		else begin
			line = (h * one) / perp;
			if (line > longint'(LINE_MAX)) line = longint'(LINE_MAX);
		end
		top = h / 2 - line / 2;
		if (top < 0) top = 0;
		bot = line / 2 + h / 2;
		if (bot >= h) bot = h - 1;
		s.top = top[11:0];
		s.bot = bot[11:0];
		s.side = sd[0];
		s.colour = sd ? COL_Y : COL_X;
		s.found = 1;
		return s;
	endfunction

	// driver: bursts and gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) void'(pending_beats.pop_front());
		if (in_valid && in_stall) begin
			// hold payload
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 0;
		end else if ((in_valid && !in_stall ? pending_beats.size() : pending_beats.size()) > 0
				&& arst_n) begin
			in_valid <= 1;
			kind <= pending_beats[0].kind;
			cell_x <= pending_beats[0].cx;
			cell_y <= pending_beats[0].cy;
			wall <= pending_beats[0].wall;
			column <= pending_beats[0].col;
			if (burst_left <= 0) begin
				burst_left <= $urandom_range(1, 20);
				if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 8);
			end else burst_left <= burst_left - 1;
		end else in_valid <= 0;
	end

	// input accept: predict on each beat taken
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			if (kind == KIND_WRITE) begin
				map_bits[{cell_y, cell_x}] = wall;
				writes++;
			end else begin
				expected_spans.push_back(cast_span(column));
				casts++;
			end
		end
	end

	// receiver stall pattern
	int stall_mode = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// monitor
	always @(posedge clk) begin
		span_t e;
		if (out_valid && !out_stall) begin
			if (expected_spans.size() == 0) begin
				$error("span beat with nothing expected, column %0d", column_out);
				errors++;
			end else begin
				e = expected_spans.pop_front();
				if (wall_found) hits++;
				if (column_out !== e.col) begin
					$error("column_out exp %0d got %0d", e.col, column_out); errors++;
				end
				if (top_row !== e.top) begin
					$error("top_row exp %0d got %0d", e.top, top_row); errors++;
				end
				if (bottom_row !== e.bot) begin
					$error("bottom_row exp %0d got %0d", e.bot, bottom_row); errors++;
				end
				if (side !== e.side) begin
					$error("side exp %0d got %0d", e.side, side); errors++;
				end
				if (colour !== e.colour) begin
					$error("colour exp %h got %h", e.colour, colour); errors++;
				end
				if (wall_found !== e.found) begin
					$error("wall_found exp %0d got %0d", e.found, wall_found); errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("FAIL grid_dda_column_raycaster");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		cam_regs[idx] = val;
	endtask

	task automatic drain();
		while (pending_beats.size() > 0 || in_valid || expected_spans.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic void push_write(int x, int y, bit w);
		beat_t b;
		b = '0; b.kind = KIND_WRITE; b.cx = 6'(x); b.cy = 6'(y); b.wall = w;
		b.col = 12'($urandom);
		pending_beats.push_back(b);
	endfunction

	function automatic void push_cast(int c);
		beat_t b;
		b = '0; b.kind = KIND_CAST; b.col = 12'(c);
		b.cx = 6'($urandom); b.cy = 6'($urandom); b.wall = 1'($urandom);
		pending_beats.push_back(b);
	endfunction

	task automatic random_setting(bit extreme);
		int w;
		w = extreme ? ($urandom_range(0, 1) ? 1 : 4096) : $urandom_range(1, 700);
		reg_write(REG_POS_X, (extreme && $urandom_range(0,1)) ? 32'h3FFFFF
			: $urandom_range(2 << 16, 62 << 16));
		reg_write(REG_POS_Y, $urandom_range(1 << 16, 63 << 16));
		reg_write(REG_DIR_X, $urandom_range(0, 262144) - 131072);
		reg_write(REG_DIR_Y, $urandom_range(0, 262144) - 131072);
		reg_write(REG_PLANE_X, $urandom_range(0, 262144) - 131072);
		reg_write(REG_PLANE_Y, $urandom_range(0, 262144) - 131072);
		reg_write(REG_SCR_W, extreme ? ($urandom_range(0, 1) ? 0 : 8191) : w);
		reg_write(REG_SCR_H, extreme ? ($urandom_range(0, 1) ? 1 : 8191)
			: $urandom_range(1, 4096));
	endtask

	initial begin
		int c;
		cam_regs = '{131072, 131072, 65536, 0, 0, 43254, 640, 480};
		foreach (map_bits[i]) map_bits[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// directed: empty map misses, border cells every ninth place, column extremes
		push_cast(0);
		push_cast(4095);
		for (int i = 0; i < 64; i += 9) begin
			push_write(i, 0, 1); push_write(i, 63, 1);
			push_write(0, i, 1); push_write(63, i, 1);
		end
		push_write(63, 63, 1);
		push_write(3, 2, 1);
		push_cast(0); push_cast(320); push_cast(639); push_cast(4095);
		drain();
		// zero dir_x component and wide plane
		reg_write(REG_DIR_X, 0); reg_write(REG_DIR_Y, 32'h7FFFF & -131072);
		reg_write(REG_PLANE_X, 131072); reg_write(REG_PLANE_Y, 0);
		reg_write(REG_SCR_W, 1); reg_write(REG_SCR_H, 0);
		push_write(2, 0, 1); push_cast(0); push_cast(1);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			random_setting(ph % 3 == 2);
			for (int n = 0; n < 200; n++) begin
				if ($urandom_range(0, 3) == 0)
					push_write($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 2) != 0);
				else begin
					c = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
						: $urandom_range(0, clampd(cam_regs[REG_SCR_W]) - 1);
					push_cast(c);
				end
			end
			drain();
		end

		$display("ran %0d casts (%0d hit a wall) and %0d map writes over 12 settings",
			casts, hits, writes);
		if (errors == 0 && expected_spans.size() == 0)
			$display("PASS grid_dda_column_raycaster");
		else
			$display("FAIL grid_dda_column_raycaster");
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/gdr_pkg.sv
hw/rtl/gdr_div.sv
hw/rtl/gdr_dp.sv
hw/rtl/gdr_ctrl.sv
hw/rtl/grid_dda_column_raycaster.sv
tb/grid_dda_column_raycaster_test.sv
